// ===== hdl/rfp_pkg.sv =====
package rfp_pkg;

    localparam logic [7:0] HEADER_FIRST  = 8'h57;
    localparam logic [7:0] HEADER_SECOND = 8'h01;
    localparam logic [2:0] CHUNK_LAST    = 3'd5;
    localparam logic [2:0] SENSOR_POS    = 3'd1;

    localparam logic KIND_ZONE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEAD2   = 3'd1,
        PH_MARK    = 3'd2,
        PH_COUNT   = 3'd3,
        PH_RECORD  = 3'd4,
        PH_TRAILER = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         sensor_id;
        logic [7:0]         zone_index;
        logic signed [23:0] distance;
        logic [7:0]         zone_status;
        logic [15:0]        strength;
        logic               checksum_ok;
    } result_t;

endpackage

// ===== hdl/rfp_parser.sv =====
module rfp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       rx_byte,
    output logic             push,
    output rfp_pkg::result_t res
);
    import rfp_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  pos_reg,    pos_next;
    logic [7:0]  sum_reg,    sum_next;
    logic [7:0]  count_reg,  count_next;
    logic [7:0]  index_reg,  index_next;
    logic [7:0]  sensor_reg, sensor_next;
    logic [39:0] rec_reg,    rec_next;

    logic [7:0]  sum_add;
    logic [7:0]  index_inc;

    assign sum_add   = sum_reg + rx_byte;
    assign index_inc = index_reg + 8'd1;

    // next state of the frame walker
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        index_next  = index_reg;
        sensor_next = sensor_reg;
        rec_next    = rec_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_HEAD2:
                begin
                    if (rx_byte == HEADER_SECOND)
                    begin
                        sum_next   = sum_add;
                        pos_next   = '0;
                        phase_next = PH_MARK;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_MARK:
                begin
                    sum_next = sum_add;
                    if (pos_reg == SENSOR_POS)
                        sensor_next = rx_byte;
                    if (pos_reg == CHUNK_LAST)
                    begin
                        pos_next   = '0;
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
                PH_COUNT:
                begin
                    sum_next   = sum_add;
                    count_next = rx_byte;
                    index_next = '0;
                    pos_next   = '0;
                    phase_next = (rx_byte == 8'd0) ? PH_TRAILER : PH_RECORD;
                end
                PH_RECORD:
                begin
                    sum_next = sum_add;
                    if (pos_reg != CHUNK_LAST)
                    begin
                        // every byte slot is written before the record completes
                        rec_next[8*pos_reg +: 8] = rx_byte;
                        pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        index_next = index_inc;
                        pos_next   = '0;
                        if (index_inc == count_reg)
                            phase_next = PH_TRAILER;
                    end
                end
                PH_TRAILER:
                begin
                    sum_next = sum_add;
                    if (pos_reg == CHUNK_LAST)
                    begin
                        pos_next   = '0;
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == HEADER_FIRST)
                    begin
                        sum_next   = HEADER_FIRST;
                        phase_next = PH_HEAD2;
                    end
                end
            endcase
        end
    end

    // result of the byte being accepted
    always_comb
    begin
        push = 1'b0;
        res  = '0;
        case (phase_reg)
            PH_RECORD:
            begin
                push            = in_fire && (pos_reg == CHUNK_LAST);
                res.kind        = KIND_ZONE;
                res.sensor_id   = sensor_reg;
                res.zone_index  = index_reg;
                res.distance    = signed'(rec_reg[23:0]);
                res.zone_status = rec_reg[31:24];
                res.strength    = {rec_reg[39:32], rx_byte};
            end
            PH_CHECK:
            begin
                push            = in_fire;
                res.kind        = KIND_VERDICT;
                res.sensor_id   = sensor_reg;
                res.checksum_ok = (rx_byte == sum_reg);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            index_reg  <= '0;
            sensor_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            index_reg  <= index_next;
            sensor_reg <= sensor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

// ===== hdl/rfp_out_buf.sv =====
module rfp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rfp_pkg::result_t push_data,
    output logic             room,
    output logic             valid,
    input  logic             ready,
    output rfp_pkg::result_t data
);
    import rfp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;
    logic    pop;

    assign pop   = main_valid_reg && ready;
    assign valid = main_valid_reg;
    assign data  = main_reg;
    assign room  = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // skid full: no push can arrive, drain it on pop
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_next = push;
            main_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hdl/ranging_frame_parser.sv =====
// A result is registered in the output buffer when the byte that completes it is accepted.
// Throughput: one byte per cycle; the two-entry output buffer sets the limit,
// and in_ready drops only while two results wait to be taken.
// Reset (rst_n low, asynchronous): the parser goes back to hunting for the
// header with all counters and the checksum cleared, and the output buffer empties.
module ranging_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [7:0]         sensor_id,
    output logic [7:0]         zone_index,
    output logic signed [23:0] distance,
    output logic [7:0]         zone_status,
    output logic [15:0]        strength,
    output logic               checksum_ok
);
    import rfp_pkg::*;

    logic    in_fire;
    logic    push;
    result_t res;
    result_t out_data;

    assign in_fire = in_valid && in_ready;

    rfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .rx_byte (rx_byte),
        .push    (push),
        .res     (res)
    );

    rfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .room      (in_ready),
        .valid     (out_valid),
        .ready     (out_ready),
        .data      (out_data)
    );

    assign kind        = out_data.kind;
    assign sensor_id   = out_data.sensor_id;
    assign zone_index  = out_data.zone_index;
    assign distance    = out_data.distance;
    assign zone_status = out_data.zone_status;
    assign strength    = out_data.strength;
    assign checksum_ok = out_data.checksum_ok;

`ifndef SYNTHESIS
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    a_zone_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_ZONE)) |-> !checksum_ok)
        else $error("zone record carries checksum flag");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_VERDICT)) |->
        ((zone_index == 8'd0) && (distance == 24'sd0) && (strength == 16'd0)))
        else $error("frame verdict carries record fields");
`endif

endmodule

// ===== test/ranging_frame_parser_tb.sv =====
`timescale 1ns / 100ps

module ranging_frame_parser_tb;

    import rfp_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_BYTES = 320;
    localparam int IDLE_PCT     = 28;
    localparam int SETTLE       = 20;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte     = 8'h00;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               kind;
    logic [7:0]         sensor_id;
    logic [7:0]         zone_index;
    logic signed [23:0] distance;
    logic [7:0]         zone_status;
    logic [15:0]        strength;
    logic               checksum_ok;

    // parser state as predicted from the accepted bytes
    phase_t      parse_phase     = PH_HUNT;
    logic [2:0]  chunk_pos       = '0;
    logic [7:0]  frame_sum       = '0;
    logic [7:0]  zones_total     = '0;
    logic [7:0]  zones_done      = '0;
    logic [7:0]  frame_sensor_id = '0;
    logic [39:0] record_buf      = '0;

    result_t     pending_results[$];

    logic [7:0]  frame_tally;
    bit          in_idle_on   = 1'b1;
    bit          out_idle_on  = 1'b1;
    int          hold_cycles  = 0;
    int          errors       = 0;
    int          cycle_count  = 0;
    int          sent_bytes   = 0;
    int          random_bytes = 0;
    int          zone_results = 0;
    int          verdicts     = 0;
    int          input_stalls = 0;

    ranging_frame_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .sensor_id   (sensor_id),
        .zone_index  (zone_index),
        .distance    (distance),
        .zone_status (zone_status),
        .strength    (strength),
        .checksum_ok (checksum_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && !in_ready)
            input_stalls++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Advance the frame decoder by one accepted byte.
    task automatic decode_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (parse_phase)
            PH_HEAD2:
                if (b == HEADER_SECOND)
                begin
                    frame_sum   = frame_sum + b;
                    chunk_pos   = '0;
                    parse_phase = PH_MARK;
                end
                else
                begin
                    // the rejected byte is not taken as a new first header byte
                    parse_phase = PH_HUNT;
                end
            PH_MARK:
            begin
                frame_sum = frame_sum + b;
                if (chunk_pos == SENSOR_POS)
                    frame_sensor_id = b;
                if (chunk_pos == CHUNK_LAST)
                begin
                    chunk_pos   = '0;
                    parse_phase = PH_COUNT;
                end
                else
                    chunk_pos = chunk_pos + 3'd1;
            end
            PH_COUNT:
            begin
                frame_sum   = frame_sum + b;
                zones_total = b;
                zones_done  = '0;
                chunk_pos   = '0;
                record_buf  = '0;
                parse_phase = (b == 8'h00) ? PH_TRAILER : PH_RECORD;
            end
            PH_RECORD:
            begin
                frame_sum = frame_sum + b;
                if (chunk_pos < CHUNK_LAST)
                begin
                    record_buf[8 * chunk_pos +: 8] = b;
                    chunk_pos = chunk_pos + 3'd1;
                end
                else
                begin
                    r.kind        = KIND_ZONE;
                    r.sensor_id   = frame_sensor_id;
                    r.zone_index  = zones_done;
                    r.distance    = record_buf[23:0];
                    r.zone_status = record_buf[31:24];
                    r.strength    = {record_buf[39:32], b};
                    pending_results.push_back(r);
                    zones_done = zones_done + 8'd1;
                    chunk_pos  = '0;
                    record_buf = '0;
                    if (zones_done == zones_total)
                        parse_phase = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                frame_sum = frame_sum + b;
                if (chunk_pos == CHUNK_LAST)
                begin
                    chunk_pos   = '0;
                    parse_phase = PH_CHECK;
                end
                else
                    chunk_pos = chunk_pos + 3'd1;
            end
            PH_CHECK:
            begin
                r.kind        = KIND_VERDICT;
                r.sensor_id   = frame_sensor_id;
                r.checksum_ok = (b == frame_sum);
                pending_results.push_back(r);
                parse_phase = PH_HUNT;
                chunk_pos   = '0;
            end
            default:
            begin
                parse_phase = PH_HUNT;
                if (b == HEADER_FIRST)
                begin
                    frame_sum   = HEADER_FIRST;
                    parse_phase = PH_HEAD2;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0h expected %0h",
                 cycle_count, field, got, want);
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result, kind", 32'(kind), 0);
            return;
        end
        want = pending_results.pop_front();
        if (want.kind == KIND_VERDICT)
            verdicts++;
        else
            zone_results++;
        if (kind !== want.kind)
            report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (sensor_id !== want.sensor_id)
            report_mismatch("sensor_id", 32'(sensor_id), 32'(want.sensor_id));
        if (zone_index !== want.zone_index)
            report_mismatch("zone_index", 32'(zone_index), 32'(want.zone_index));
        if (distance !== want.distance)
            report_mismatch("distance", {8'h00, distance}, {8'h00, want.distance});
        if (zone_status !== want.zone_status)
            report_mismatch("zone_status", 32'(zone_status), 32'(want.zone_status));
        if (strength !== want.strength)
            report_mismatch("strength", 32'(strength), 32'(want.strength));
        if (checksum_ok !== want.checksum_ok)
            report_mismatch("checksum_ok", 32'(checksum_ok), 32'(want.checksum_ok));
    endtask

    // Result side: check on each taken result, then pick next cycle's ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else if (out_idle_on && $urandom_range(0, 99) < IDLE_PCT)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] b);
        while (in_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b);
        sent_bytes++;
    endtask

    task automatic send_counted(input logic [7:0] b);
        frame_tally = frame_tally + b;
        send_byte(b);
    endtask

    task automatic open_frame(input logic [7:0] sensor, input logic [7:0] count);
        int i;
        frame_tally = '0;
        send_counted(HEADER_FIRST);
        send_counted(HEADER_SECOND);
        for (i = 0; i <= CHUNK_LAST; i++)
            send_counted(i == SENSOR_POS ? sensor : 8'($urandom));
        send_counted(count);
    endtask

    task automatic send_record(input logic [23:0] zone_dist, input logic [7:0] status,
                               input logic [15:0] str);
        send_counted(zone_dist[7:0]);
        send_counted(zone_dist[15:8]);
        send_counted(zone_dist[23:16]);
        send_counted(status);
        send_counted(str[15:8]);
        send_counted(str[7:0]);
    endtask

    task automatic close_frame(input bit corrupt);
        int         i;
        logic [7:0] sum;
        for (i = 0; i <= CHUNK_LAST; i++)
            send_counted(8'($urandom));
        sum = frame_tally;
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic send_random_frame(input logic [7:0] count, input bit corrupt);
        int i;
        open_frame(8'($urandom), count);
        for (i = 0; i < count; i++)
            send_record(24'($urandom), 8'($urandom), 16'($urandom));
        close_frame(corrupt);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_field_extremes();
        open_frame(8'h00, 8'd3);
        send_record(24'h7FFFFF, 8'h00, 16'hFFFF);
        send_record(24'h800000, 8'hFF, 16'h0000);
        send_record(24'hFFFFFF, 8'h5A, 16'h8001);
        close_frame(1'b0);
        open_frame(8'hFF, 8'd1);
        send_record(24'h000000, 8'hA5, 16'h7FFE);
        close_frame(1'b0);
    endtask

    task automatic test_empty_and_bad_checksum();
        open_frame(8'h3C, 8'd0);
        close_frame(1'b0);
        open_frame(8'hC3, 8'd0);
        close_frame(1'b1);
        open_frame(8'h81, 8'd1);
        send_record(24'h123456, 8'h01, 16'h0102);
        close_frame(1'b1);
    endtask

    task automatic test_header_hunt();
        // noise, then a broken header, then 57 57 01 where the 01 must be ignored
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HEADER_SECOND);
        send_byte(HEADER_FIRST);
        send_byte(8'h02);
        send_byte(HEADER_FIRST);
        send_byte(HEADER_FIRST);
        send_byte(HEADER_SECOND);
        send_random_frame(8'd1, 1'b0);
    endtask

    task automatic test_output_holdoff();
        // hold the result side long enough for the output buffer to back up
        hold_cycles = 120;
        send_random_frame(8'd10, 1'b0);
    endtask

    task automatic test_random_stream();
        int         pick;
        int         n;
        int         i;
        logic [7:0] count;
        int         start_count;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        while (random_bytes < RANDOM_BYTES)
        begin
            if (random_bytes > 150)
            begin
                in_idle_on  = 1'b1;
                out_idle_on = 1'b1;
            end
            pick        = $urandom_range(0, 99);
            start_count = sent_bytes;
            if (pick < 75)
            begin
                // keep late frames short so the stream ends near its budget
                n = $urandom_range(0, 99);
                if (n >= 92 && random_bytes + 210 < RANDOM_BYTES)
                    count = 8'($urandom_range(21, 32));
                else if (n >= 70 && random_bytes + 140 < RANDOM_BYTES)
                    count = 8'($urandom_range(5, 20));
                else
                    count = 8'($urandom_range(0, 4));
                send_random_frame(count, $urandom_range(0, 99) < 15);
                random_bytes += sent_bytes - start_count;
            end
            else if (pick < 87)
            begin
                // line noise; the parser should mostly ignore it
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    send_byte(8'($urandom));
            end
            else
            begin
                send_byte(HEADER_FIRST);
                if ($urandom_range(0, 1))
                    send_byte(HEADER_FIRST);
                else
                    send_byte(8'($urandom_range(2, 255)));
                send_byte(HEADER_SECOND);
                random_bytes += sent_bytes - start_count;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_empty_and_bad_checksum();
        test_header_hunt();
        test_output_holdoff();
        drop_valid();
        test_random_stream();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("tb: %0d bytes sent (%0d in the random stream), %0d zone records",
                 sent_bytes, random_bytes, zone_results);
        $display("tb: %0d frame verdicts, input held off for %0d cycles, %0d mismatches",
                 verdicts, input_stalls, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
